// ===== hw/rtl/imu_steady_state_kalman_attitude_macros.svh =====
// Assertion helpers used by the checker file imuk_checker.sv.
// Every assertion is clocked on clk and disabled while rst_n is low.
`ifndef IMU_STEADY_STATE_KALMAN_ATTITUDE_MACROS_SVH
`define IMU_STEADY_STATE_KALMAN_ATTITUDE_MACROS_SVH

// A plain property under the common clock and reset.
`define IMU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A signal holds its value in the cycle after a condition.
`define IMU_ASSERT_HOLD(label, cond, sig, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (cond) |=> $stable(sig)) else $error(msg);

`endif

// ===== hw/rtl/imuk_pkg.sv =====
package imuk_pkg;

    // CORDIC default step count and step index width.
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int STEP_IDX_W       = 5;

    // Datapath widths: CORDIC x/y, angle accumulator, estimate, output.
    localparam int CW = 28;
    localparam int ZW = 29;
    localparam int EW = 32;
    localparam int OW = 22;

    localparam logic signed [ZW-1:0] ANG_PI     = 29'sd52707179;
    localparam logic signed [23:0]   DEG_MUL    = 24'sd3754936;
    localparam logic [15:0]          GAIN_RESET = 16'd1638;

    typedef enum logic [1:0] {
        AXIS_ROLL,
        AXIS_PITCH,
        AXIS_YAW
    } axis_t;

    typedef enum logic [1:0] {
        REG_GAIN_ROLL,
        REG_GAIN_PITCH,
        REG_GAIN_YAW
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CINIT,
        ST_CITER,
        ST_UMUL,
        ST_USUM,
        ST_DMUL,
        ST_DSAT,
        ST_PUB
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                  load;
        logic                  cord_init;
        logic                  cord_iter;
        logic                  upd_mul;
        logic                  upd_sum;
        logic                  deg_mul;
        logic                  deg_sat;
        logic                  publish;
        axis_t                 axis;
        logic [STEP_IDX_W-1:0] step;
    } dp_cmd_t;

    // Arctangent of 2^-i in 2^-24 rad.
    function automatic logic [23:0] atan_val(input logic [STEP_IDX_W-1:0] i);
        logic [23:0] v;
        case (i)
            5'd0:    v = 24'd13176795;
            5'd1:    v = 24'd7778716;
            5'd2:    v = 24'd4110060;
            5'd3:    v = 24'd2086331;
            5'd4:    v = 24'd1047214;
            5'd5:    v = 24'd524117;
            5'd6:    v = 24'd262123;
            5'd7:    v = 24'd131069;
            5'd8:    v = 24'd65536;
            5'd9:    v = 24'd32768;
            5'd10:   v = 24'd16384;
            5'd11:   v = 24'd8192;
            5'd12:   v = 24'd4096;
            5'd13:   v = 24'd2048;
            5'd14:   v = 24'd1024;
            5'd15:   v = 24'd512;
            5'd16:   v = 24'd256;
            5'd17:   v = 24'd128;
            5'd18:   v = 24'd64;
            5'd19:   v = 24'd32;
            5'd20:   v = 24'd16;
            5'd21:   v = 24'd8;
            5'd22:   v = 24'd4;
            5'd23:   v = 24'd2;
            default: v = 24'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/imuk_if.sv =====
// Sample channel: one IMU sample per beat.
interface imuk_sample_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
    logic [15:0]        step_time;

    modport source (output valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z,
                    step_time, input ready);
    modport sink (input valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z,
                  step_time, output ready);
endinterface

// Angle channel: three estimates in 1/256 degree per beat.
interface imuk_angle_if;
    logic               valid;
    logic               ready;
    logic signed [21:0] angle_roll_deg;
    logic signed [21:0] angle_pitch_deg;
    logic signed [21:0] angle_yaw_deg;

    modport source (output valid, angle_roll_deg, angle_pitch_deg, angle_yaw_deg,
                    input ready);
    modport sink (input valid, angle_roll_deg, angle_pitch_deg, angle_yaw_deg,
                  output ready);
endinterface

// ===== hw/rtl/imuk_ctrl.sv =====
module imuk_ctrl #(
    parameter int CORDIC_STEPS = imuk_pkg::CORDIC_STEPS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output imuk_pkg::dp_cmd_t cmd
);
    import imuk_pkg::*;

    localparam int STEP_W = $clog2(CORDIC_STEPS);

    state_t             state_reg, state_next;
    axis_t              axis_reg, axis_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               out_valid_reg, out_valid_next;

    // State, axis, step and output-valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            axis_reg      <= AXIS_ROLL;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Sequencing: CORDIC then update and degree conversion, one axis at a time.
    always_comb
    begin
        state_next     = state_reg;
        axis_next      = axis_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = 1'b0;
        cmd            = '0;
        cmd.axis       = axis_reg;
        cmd.step       = STEP_IDX_W'(step_reg);
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    axis_next  = AXIS_ROLL;
                    state_next = ST_CINIT;
                end
            end
            ST_CINIT:
            begin
                cmd.cord_init = 1'b1;
                step_next     = '0;
                state_next    = ST_CITER;
            end
            ST_CITER:
            begin
                cmd.cord_iter = 1'b1;
                if (step_reg == STEP_W'(CORDIC_STEPS - 1))
                begin
                    state_next = ST_UMUL;
                end
                else
                begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            ST_UMUL:
            begin
                cmd.upd_mul = 1'b1;
                state_next  = ST_USUM;
            end
            ST_USUM:
            begin
                cmd.upd_sum = 1'b1;
                state_next  = ST_DMUL;
            end
            ST_DMUL:
            begin
                cmd.deg_mul = 1'b1;
                state_next  = ST_DSAT;
            end
            ST_DSAT:
            begin
                cmd.deg_sat = 1'b1;
                case (axis_reg)
                    AXIS_ROLL:  axis_next = AXIS_PITCH;
                    AXIS_PITCH: axis_next = AXIS_YAW;
                    default:    axis_next = AXIS_ROLL;
                endcase
                state_next = (axis_reg == AXIS_YAW) ? ST_PUB : ST_CINIT;
            end
            ST_PUB:
            begin
                // Wait for the output register to be free.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.publish    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== hw/rtl/imuk_datapath.sv =====
module imuk_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  imuk_pkg::dp_cmd_t  cmd,
    input  logic               wr_en,
    input  logic [1:0]         wr_index,
    input  logic [15:0]        wr_data,
    input  logic signed [15:0] accel_x,
    input  logic signed [15:0] accel_y,
    input  logic signed [15:0] accel_z,
    input  logic signed [15:0] rate_x,
    input  logic signed [15:0] rate_y,
    input  logic signed [15:0] rate_z,
    input  logic [15:0]        step_time,
    output logic signed [21:0] angle_roll_deg,
    output logic signed [21:0] angle_pitch_deg,
    output logic signed [21:0] angle_yaw_deg
);
    import imuk_pkg::*;

    logic signed [15:0] ax_reg, ay_reg, az_reg, rx_reg, ry_reg, rz_reg;
    logic [15:0]        dt_reg;
    logic [15:0]        gain_reg [3];
    logic signed [EW-1:0] est_reg [3];
    logic signed [OW-1:0] res_reg [3];
    logic signed [OW-1:0] out_reg [3];

    logic signed [CW-1:0] x_reg, y_reg, x_next, y_next;
    logic signed [ZW-1:0] z_reg, z_next;
    logic                 zero_reg, zero_next;

    logic signed [32:0] gyro_prod_reg, gyro_prod_next;
    logic signed [49:0] corr_prod_reg, corr_prod_next;
    logic signed [55:0] deg_prod_reg, deg_prod_next;

    logic signed [15:0]   ya, xa, rate_sel;
    logic [15:0]          gain_sel;
    logic signed [EW-1:0] est_sel, est_next;
    logic signed [OW-1:0] res_next;
    logic signed [16:0]   yn, xn;
    logic signed [CW-1:0] ys, xs, dx, dy;
    logic signed [ZW-1:0] at, meas;
    logic signed [32:0]   diff, gyro;
    logic signed [49:0]   corr_round;
    logic signed [35:0]   total;
    logic signed [55:0]   deg_round;
    logic signed [23:0]   deg;
    logic [1:0]           ax_idx;

    assign ax_idx = cmd.axis;

    // Per-axis operand selection.
    always_comb
    begin
        case (cmd.axis)
            AXIS_ROLL:
            begin
                ya = ax_reg; xa = az_reg; rate_sel = rx_reg;
            end
            AXIS_PITCH:
            begin
                ya = ay_reg; xa = az_reg; rate_sel = ry_reg;
            end
            default:
            begin
                ya = ax_reg; xa = ay_reg; rate_sel = rz_reg;
            end
        endcase
        gain_sel = gain_reg[ax_idx == 2'd3 ? 2'd2 : ax_idx];
        est_sel  = est_reg[ax_idx == 2'd3 ? 2'd2 : ax_idx];
    end

    // CORDIC start and one vectoring step.
    always_comb
    begin
        yn = -{ya[15], ya};
        xn = -{xa[15], xa};
        ys = {{(CW-25){yn[16]}}, yn, 8'b0};
        xs = {{(CW-25){xn[16]}}, xn, 8'b0};
        dx = y_reg >>> cmd.step;
        dy = x_reg >>> cmd.step;
        at = ZW'(atan_val(cmd.step));
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        zero_next = zero_reg;
        if (cmd.cord_init)
        begin
            zero_next = (ya == 16'sd0) && (xa == 16'sd0);
            if (xs < 0)
            begin
                z_next = (ys >= 0) ? ANG_PI : -ANG_PI;
                x_next = -xs;
                y_next = -ys;
            end
            else
            begin
                z_next = '0;
                x_next = xs;
                y_next = ys;
            end
        end
        else if (cmd.cord_iter)
        begin
            if (y_reg >= 0)
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + at;
            end
            else
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - at;
            end
        end
    end

    // Products, rounding and saturation of the estimate update and the degree conversion.
    always_comb
    begin
        meas = zero_reg ? '0 : z_reg;
        diff = 33'(meas) - 33'(est_sel);
        gyro_prod_next = 33'(rate_sel) * 33'($signed({1'b0, dt_reg}));
        corr_prod_next = 50'(diff) * 50'($signed({1'b0, gain_sel}));
        gyro = (gyro_prod_reg + 33'sd8) >>> 4;
        corr_round = (corr_prod_reg + 50'sd16384) >>> 15;
        total = 36'(est_sel) + 36'(gyro) + 36'(corr_round);
        if (total > 36'sd2147483647)
        begin
            est_next = 32'sh7fffffff;
        end
        else if (total < -36'sd2147483648)
        begin
            est_next = 32'sh80000000;
        end
        else
        begin
            est_next = 32'(total);
        end
        deg_prod_next = 56'(est_sel) * 56'(DEG_MUL);
        deg_round = (deg_prod_reg + 56'sd2147483648) >>> 32;
        deg = 24'(deg_round);
        if (deg > 24'sd2097151)
        begin
            res_next = 22'sh1fffff;
        end
        else if (deg < -24'sd2097152)
        begin
            res_next = 22'sh200000;
        end
        else
        begin
            res_next = 22'(deg);
        end
    end

    // Gains and estimates, the block's reset state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
            begin
                gain_reg[k] <= GAIN_RESET;
                est_reg[k]  <= '0;
            end
        end
        else
        begin
            if (wr_en)
            begin
                case (wr_index)
                    REG_GAIN_ROLL:  gain_reg[0] <= wr_data;
                    REG_GAIN_PITCH: gain_reg[1] <= wr_data;
                    REG_GAIN_YAW:   gain_reg[2] <= wr_data;
                    default:        ;
                endcase
            end
            if (cmd.upd_sum && ax_idx != 2'd3)
            begin
                est_reg[ax_idx] <= est_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ax_reg <= accel_x;
            ay_reg <= accel_y;
            az_reg <= accel_z;
            rx_reg <= rate_x;
            ry_reg <= rate_y;
            rz_reg <= rate_z;
            dt_reg <= step_time;
        end
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        zero_reg <= zero_next;
        if (cmd.upd_mul)
        begin
            gyro_prod_reg <= gyro_prod_next;
            corr_prod_reg <= corr_prod_next;
        end
        if (cmd.deg_mul)
        begin
            deg_prod_reg <= deg_prod_next;
        end
        if (cmd.deg_sat && ax_idx != 2'd3)
        begin
            res_reg[ax_idx] <= res_next;
        end
        if (cmd.publish)
        begin
            out_reg <= res_reg;
        end
    end

    assign angle_roll_deg  = out_reg[0];
    assign angle_pitch_deg = out_reg[1];
    assign angle_yaw_deg   = out_reg[2];

endmodule

// ===== hw/rtl/imu_steady_state_kalman_attitude.sv =====
// Attitude estimator: each sample beat yields one beat of three angle estimates in
// 1/256 degree. A single shared CORDIC unit forms the three measured angles in turn,
// and one update path adds the gyro term and the gain-weighted correction per axis.
// After acceptance each of the three axes runs a start step, the CORDIC iterations,
// one per cycle, and the multiply, sum, degree-multiply and saturate update steps;
// the publish step then waits for the output register to be free. The next sample is
// taken while a result still waits in the output register. Gains must be written
// only while the block is idle; the block itself does not enforce this.
module imu_steady_state_kalman_attitude #(
    parameter int CORDIC_STEPS = imuk_pkg::CORDIC_STEPS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  logic [1:0]    wr_index,
    input  logic [15:0]   wr_data,
    imuk_sample_if.sink   sample,
    imuk_angle_if.source  angles
);
    import imuk_pkg::*;

    dp_cmd_t cmd;

    // Sequencer.
    imuk_ctrl #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample.valid),
        .in_ready (sample.ready),
        .out_valid(angles.valid),
        .out_ready(angles.ready),
        .cmd      (cmd)
    );

    // CORDIC, filter update and output registers.
    imuk_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .wr_en          (wr_en),
        .wr_index       (wr_index),
        .wr_data        (wr_data),
        .accel_x        (sample.accel_x),
        .accel_y        (sample.accel_y),
        .accel_z        (sample.accel_z),
        .rate_x         (sample.rate_x),
        .rate_y         (sample.rate_y),
        .rate_z         (sample.rate_z),
        .step_time      (sample.step_time),
        .angle_roll_deg (angles.angle_roll_deg),
        .angle_pitch_deg(angles.angle_pitch_deg),
        .angle_yaw_deg  (angles.angle_yaw_deg)
    );

endmodule

// ===== hw/rtl/imuk_checker.sv =====
`include "imu_steady_state_kalman_attitude_macros.svh"

module imuk_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [65:0] out_data
);
    // A result beat waits until it is taken, with its payload held.
    `IMU_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result beat dropped")
    `IMU_ASSERT_HOLD(a_out_stable, out_valid && !out_ready, out_data, "result changed")
    // The block is busy right after taking a sample.
    `IMU_ASSERT(a_busy, in_valid && in_ready |=> !in_ready, "sample taken while busy")
    // A new result appears only at the end of work, never from idle.
    `IMU_ASSERT(a_rise, $rose(out_valid) |-> $past(!in_ready), "result without work")

endmodule

bind imu_steady_state_kalman_attitude imuk_checker u_imuk_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (sample.valid),
    .in_ready (sample.ready),
    .out_valid(angles.valid),
    .out_ready(angles.ready),
    .out_data ({angles.angle_roll_deg, angles.angle_pitch_deg, angles.angle_yaw_deg})
);
